// ----- rtl/ata_pio_lba48_command_engine_assert.svh -----
// assertion macros for the command engine
`ifndef ATA_PIO_LBA48_COMMAND_ENGINE_ASSERT_SVH
`define ATA_PIO_LBA48_COMMAND_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define ACE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ACE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ACE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ACE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/ace_pkg.sv -----
`default_nettype none
package ace_pkg;
    localparam int WordsPerSectorDef = 256;
    localparam int MaxSectorsDef     = 256;
    localparam int QueueDepth        = 4;
    localparam int JobMax            = 16;

    localparam logic [1:0] REQ_READ   = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_STATUS = 2'd2;
    localparam logic [1:0] REQ_DATA   = 2'd3;

    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_BWR    = 3'd1;
    localparam logic [2:0] OP_STAT   = 3'd2;
    localparam logic [2:0] OP_SETTLE = 3'd3;
    localparam logic [2:0] OP_DRD    = 3'd4;
    localparam logic [2:0] OP_DWR    = 3'd5;

    localparam logic [1:0] OUT_OK   = 2'd0;
    localparam logic [1:0] OUT_REJ  = 2'd1;
    localparam logic [1:0] OUT_FAIL = 2'd2;

    localparam logic [1:0] CFG_ENABLED = 2'd0;
    localparam logic [1:0] CFG_RETRY   = 2'd1;
    localparam logic [1:0] CFG_POLL    = 2'd2;

    localparam logic [47:0] LbaMax = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [47:0] lba;
        logic [8:0]  num_sectors;
        logic [7:0]  status;
        logic [15:0] data_word;
    } req_t;

    typedef struct packed {
        logic [2:0]  bus_op;
        logic [3:0]  reg_sel;
        logic [15:0] bus_value;
        logic        host_word_valid;
        logic [15:0] host_word;
        logic        done_res;
        logic [1:0]  outcome;
        logic        last;
    } res_t;

    // job kinds handed from the sequencer to the result generator
    localparam logic [3:0] JOB_SINGLE  = 4'd0;  // one result held in the beat
    localparam logic [3:0] JOB_BEGIN   = 4'd1;  // select + settle + poll
    localparam logic [3:0] JOB_FAIL    = 4'd2;  // soft reset, then begin or fail
    localparam logic [3:0] JOB_PROGRAM = 4'd3;  // task file + command + settle + poll
    localparam logic [3:0] JOB_WORD    = 4'd4;  // host word, then read / poll / finish
    localparam logic [3:0] JOB_FLUSH   = 4'd5;  // flush command + poll
    localparam logic [3:0] JOB_WRWORD  = 4'd6;  // data write, then poll / flush / finish

    localparam logic [1:0] TAIL_NONE   = 2'd0;
    localparam logic [1:0] TAIL_BEGIN  = 2'd1;
    localparam logic [1:0] TAIL_FINISH = 2'd2;
    localparam logic [1:0] TAIL_POLL   = 2'd3;

    typedef struct packed {
        logic [3:0]  kind;
        logic [1:0]  tail;       // what follows the word / fail sequence
        logic        tail_rd;    // a data read follows the host word
        logic [1:0]  fin_code;
        logic        is_write;
        logic [47:0] lba;
        logic [8:0]  count;
        logic [15:0] word;
        res_t        single;
    } job_t;

    function automatic res_t mk_res(logic [2:0] op, logic [3:0] rs, logic [15:0] v);
        res_t r;
        r = '0;
        r.bus_op = op;
        r.reg_sel = rs;
        r.bus_value = v;
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/ace_stream_if.sv -----
`default_nettype none
interface ace_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/ace_front.sv -----
`default_nettype none
module ace_front #(
    parameter int WORDS_PER_SECTOR = 256,
    parameter int MAX_SECTORS      = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire ace_pkg::req_t req,
    input  wire logic        enabled,
    input  wire logic [2:0]  retry_limit,
    input  wire logic [19:0] poll_limit,
    output logic             job_valid,
    output ace_pkg::job_t    job,
    input  wire logic        job_ready
);
    import ace_pkg::*;
    `include "ata_pio_lba48_command_engine_assert.svh"

    localparam int WW = $clog2(WORDS_PER_SECTOR + 1);
    localparam logic [2:0] PH_IDLE = 3'd0, PH_SEL_BSY = 3'd1, PH_SEC_BSY = 3'd2,
        PH_SEC_DRQ = 3'd3, PH_RD_DATA = 3'd4, PH_WR_DATA = 3'd5, PH_FLUSH_BSY = 3'd6;

    logic [2:0]    phase_reg, phase_next;
    logic          is_write_reg, is_write_next;
    logic [47:0]   lba_reg, lba_next;
    logic [8:0]    count_reg, count_next;
    logic [8:0]    sectors_reg, sectors_next;
    logic [WW-1:0] words_reg, words_next;
    logic [19:0]   poll_reg, poll_next;
    logic [2:0]    att_reg, att_next;
    logic          emit;
    job_t          j;
    logic          bsy, drq, err, fire;
    logic [19:0]   plim;
    logic [2:0]    rlim;
    logic [2:0]    att_inc;
    logic [8:0]    sec_dec;
    logic [WW-1:0] words_dec;

    assign in_ready = job_ready;
    assign fire = in_valid && in_ready;
    assign job_valid = fire && emit;
    assign job = j;
    assign bsy = req.status[7];
    assign drq = req.status[3];
    assign err = req.status[0];
    assign plim = (poll_limit == '0) ? 20'd1 : poll_limit;
    assign rlim = (retry_limit == '0) ? 3'd1 : retry_limit;
    assign att_inc = att_reg + 3'd1;
    assign sec_dec = (sectors_reg != '0) ? sectors_reg - 9'd1 : sectors_reg;
    assign words_dec = (words_reg != '0) ? words_reg - 1'b1 : words_reg;

    // classify the beat and update the sequencer state
    always_comb
    begin
        phase_next = phase_reg;
        is_write_next = is_write_reg;
        lba_next = lba_reg;
        count_next = count_reg;
        sectors_next = sectors_reg;
        words_next = words_reg;
        poll_next = poll_reg;
        att_next = att_reg;
        emit = 1'b0;
        j = '0;
        j.is_write = is_write_reg;
        j.lba = lba_reg;
        j.count = count_reg;
        j.word = req.data_word;
        case (req.req_type)
            REQ_READ, REQ_WRITE:
            begin
                emit = 1'b1;
                j.kind = JOB_SINGLE;
                j.single.done_res = 1'b1;
                j.single.outcome = OUT_REJ;
                if (phase_reg == PH_IDLE && enabled && req.num_sectors != '0
                    && {1'b0, req.num_sectors} <= 10'(MAX_SECTORS)
                    && {39'd0, req.num_sectors - 9'd1} <= LbaMax - req.lba)
                begin
                    j.kind = JOB_BEGIN;
                    j.is_write = req.req_type[0];
                    j.lba = req.lba;
                    j.count = req.num_sectors;
                    is_write_next = req.req_type[0];
                    lba_next = req.lba;
                    count_next = req.num_sectors;
                    att_next = '0;
                    sectors_next = req.num_sectors;
                    words_next = '0;
                    poll_next = 20'd1;
                    phase_next = PH_SEL_BSY;
                end
            end
            REQ_STATUS:
            begin
                if (phase_reg == PH_SEL_BSY || phase_reg == PH_SEC_BSY
                    || phase_reg == PH_SEC_DRQ || phase_reg == PH_FLUSH_BSY)
                begin
                    emit = 1'b1;
                    if ((phase_reg != PH_SEC_DRQ && bsy) ||
                        (phase_reg == PH_SEC_DRQ && !err && !drq))
                    begin
                        if (poll_reg >= plim)
                        begin
                            j.kind = JOB_FAIL;
                        end
                        else
                        begin
                            poll_next = poll_reg + 20'd1;
                            j.kind = JOB_SINGLE;
                            j.single = mk_res(OP_STAT, 4'd7, 16'd0);
                        end
                    end
                    else if (err)
                        j.kind = JOB_FAIL;
                    else
                    begin
                        case (phase_reg)
                            PH_SEL_BSY:
                            begin
                                j.kind = JOB_PROGRAM;
                                poll_next = 20'd1;
                                phase_next = PH_SEC_BSY;
                            end
                            PH_SEC_BSY:
                            begin
                                j.kind = JOB_SINGLE;
                                j.single = mk_res(OP_STAT, 4'd7, 16'd0);
                                poll_next = 20'd1;
                                phase_next = PH_SEC_DRQ;
                            end
                            PH_SEC_DRQ:
                            begin
                                words_next = WW'(WORDS_PER_SECTOR);
                                if (is_write_reg)
                                begin
                                    emit = 1'b0;
                                    phase_next = PH_WR_DATA;
                                end
                                else
                                begin
                                    j.kind = JOB_SINGLE;
                                    j.single = mk_res(OP_DRD, 4'd0, 16'd0);
                                    phase_next = PH_RD_DATA;
                                end
                            end
                            default:
                            begin
                                j.kind = JOB_SINGLE;
                                j.single.done_res = 1'b1;
                                j.single.outcome = OUT_OK;
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                    if (j.kind == JOB_FAIL)
                    begin
                        att_next = att_inc;
                        if (att_inc >= rlim || !enabled)
                        begin
                            j.tail = TAIL_FINISH;
                            j.fin_code = OUT_FAIL;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            j.tail = TAIL_BEGIN;
                            sectors_next = count_reg;
                            words_next = '0;
                            poll_next = 20'd1;
                            phase_next = PH_SEL_BSY;
                        end
                    end
                end
            end
            default:
            begin
                if (phase_reg == PH_RD_DATA || phase_reg == PH_WR_DATA)
                begin
                    emit = 1'b1;
                    j.kind = (phase_reg == PH_RD_DATA) ? JOB_WORD : JOB_WRWORD;
                    words_next = words_dec;
                    j.tail = TAIL_NONE;
                    if (phase_reg == PH_RD_DATA && words_dec != '0)
                        j.tail_rd = 1'b1;
                    else if (words_dec == '0)
                    begin
                        sectors_next = sec_dec;
                        if (sec_dec != '0)
                        begin
                            j.tail = TAIL_POLL;
                            poll_next = 20'd1;
                            phase_next = PH_SEC_BSY;
                        end
                        else if (is_write_reg)
                        begin
                            j.tail = TAIL_BEGIN;
                            poll_next = 20'd1;
                            phase_next = PH_FLUSH_BSY;
                        end
                        else
                        begin
                            j.tail = TAIL_FINISH;
                            j.fin_code = OUT_OK;
                            phase_next = PH_IDLE;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            is_write_reg <= 1'b0;
            lba_reg <= '0;
            count_reg <= '0;
            sectors_reg <= '0;
            words_reg <= '0;
            poll_reg <= '0;
            att_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            is_write_reg <= is_write_next;
            lba_reg <= lba_next;
            count_reg <= count_next;
            sectors_reg <= sectors_next;
            words_reg <= words_next;
            poll_reg <= poll_next;
            att_reg <= att_next;
        end
    end

    `ACE_ASSERT_IMP(a_data_has_words, clk, rst_n,
        (phase_reg == PH_RD_DATA || phase_reg == PH_WR_DATA), (words_reg != '0))
    `ACE_ASSERT_IMP(a_busy_has_sectors, clk, rst_n,
        (phase_reg == PH_SEC_BSY || phase_reg == PH_SEC_DRQ), (sectors_reg != '0))
    `ACE_ASSERT_NEXT(a_start_to_select, clk, rst_n,
        (fire && emit && j.kind == JOB_BEGIN && req.req_type[1] == 1'b0),
        (phase_reg == PH_SEL_BSY && poll_reg == 20'd1))
endmodule
`default_nettype wire

// ----- rtl/ace_back.sv -----
`default_nettype none
module ace_back (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      job_valid,
    input  wire ace_pkg::job_t job,
    output logic           job_ready,
    output logic           res_valid,
    output ace_pkg::res_t  res,
    input  wire logic      res_ready
);
    import ace_pkg::*;
    `include "ata_pio_lba48_command_engine_assert.svh"

    // small job queue
    localparam int AW = $clog2(QueueDepth);
    job_t        q_mem [QueueDepth];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          push, pop;
    job_t        cur;
    logic [4:0]  step_reg;
    logic [4:0]  nsteps;
    res_t        r;
    logic        out_valid_reg;
    res_t        out_reg;
    logic        adv;

    assign job_ready = (cnt_reg != (AW+1)'(QueueDepth));
    assign push = job_valid && job_ready;
    assign cur = q_mem[rp_reg];
    assign adv = (cnt_reg != '0) && (!out_valid_reg || res_ready);
    assign pop = adv && (step_reg == nsteps - 5'd1);
    assign res_valid = out_valid_reg;
    assign res = out_reg;

    // number of results per job
    always_comb
    begin
        case (cur.kind)
            JOB_SINGLE:  nsteps = 5'd1;
            JOB_BEGIN:   nsteps = 5'd6;
            JOB_FAIL:    nsteps = (cur.tail == TAIL_BEGIN) ? 5'd16 : 5'd11;
            JOB_PROGRAM: nsteps = 5'd14;
            JOB_FLUSH:   nsteps = 5'd2;
            JOB_WORD:    nsteps = (cur.tail == TAIL_POLL || cur.tail == TAIL_FINISH
                                   || cur.tail_rd) ? 5'd2 :
                                  (cur.tail == TAIL_BEGIN) ? 5'd3 : 5'd1;
            default:     nsteps = (cur.tail == TAIL_POLL || cur.tail == TAIL_FINISH) ?
                                  5'd2 : (cur.tail == TAIL_BEGIN) ? 5'd3 : 5'd1;
        endcase
    end

    // result for the current step
    always_comb
    begin
        logic [4:0] s;
        s = step_reg;
        r = '0;
        case (cur.kind)
            JOB_SINGLE: r = cur.single;
            JOB_BEGIN:
            begin
                if (s == 5'd0) r = mk_res(OP_BWR, 4'd6, 16'h0040);
                else if (s == 5'd5) r = mk_res(OP_STAT, 4'd7, 16'd0);
                else r = mk_res(OP_SETTLE, 4'd8, 16'd0);
            end
            JOB_FAIL:
            begin
                if (s == 5'd0) r = mk_res(OP_BWR, 4'd8, 16'h0004);
                else if (s == 5'd5) r = mk_res(OP_BWR, 4'd8, 16'h0000);
                else if (s < 5'd10) r = mk_res(OP_SETTLE, 4'd8, 16'd0);
                else if (cur.tail == TAIL_FINISH)
                begin
                    r.done_res = 1'b1;
                    r.outcome = cur.fin_code;
                end
                else if (s == 5'd10) r = mk_res(OP_BWR, 4'd6, 16'h0040);
                else if (s == 5'd15) r = mk_res(OP_STAT, 4'd7, 16'd0);
                else r = mk_res(OP_SETTLE, 4'd8, 16'd0);
            end
            JOB_PROGRAM:
            begin
                case (s)
                    5'd0: r = mk_res(OP_BWR, 4'd2, {15'd0, cur.count[8]});
                    5'd1: r = mk_res(OP_BWR, 4'd3, {8'd0, cur.lba[31:24]});
                    5'd2: r = mk_res(OP_BWR, 4'd4, {8'd0, cur.lba[39:32]});
                    5'd3: r = mk_res(OP_BWR, 4'd5, {8'd0, cur.lba[47:40]});
                    5'd4: r = mk_res(OP_BWR, 4'd2, {8'd0, cur.count[7:0]});
                    5'd5: r = mk_res(OP_BWR, 4'd3, {8'd0, cur.lba[7:0]});
                    5'd6: r = mk_res(OP_BWR, 4'd4, {8'd0, cur.lba[15:8]});
                    5'd7: r = mk_res(OP_BWR, 4'd5, {8'd0, cur.lba[23:16]});
                    5'd8: r = mk_res(OP_BWR, 4'd7, cur.is_write ? 16'h0034 : 16'h0024);
                    5'd13: r = mk_res(OP_STAT, 4'd7, 16'd0);
                    default: r = mk_res(OP_SETTLE, 4'd8, 16'd0);
                endcase
            end
            JOB_FLUSH:
                r = (s == 5'd0) ? mk_res(OP_BWR, 4'd7, 16'h00EA) : mk_res(OP_STAT, 4'd7, 16'd0);
            default:
            begin
                if (s == 5'd0)
                begin
                    if (cur.kind == JOB_WORD)
                    begin
                        r.host_word_valid = 1'b1;
                        r.host_word = cur.word;
                    end
                    else
                        r = mk_res(OP_DWR, 4'd0, cur.word);
                end
                else if (cur.tail_rd) r = mk_res(OP_DRD, 4'd0, 16'd0);
                else if (cur.tail == TAIL_POLL) r = mk_res(OP_STAT, 4'd7, 16'd0);
                else if (cur.tail == TAIL_FINISH)
                begin
                    r.done_res = 1'b1;
                    r.outcome = cur.fin_code;
                end
                else if (s == 5'd1) r = mk_res(OP_BWR, 4'd7, 16'h00EA);
                else r = mk_res(OP_STAT, 4'd7, 16'd0);
            end
        endcase
        r.last = (step_reg == nsteps - 5'd1);
    end

    always_ff @(posedge clk)
    begin
        if (push) q_mem[wp_reg] <= job;
        if (adv) out_reg <= r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
            step_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
            if (adv) step_reg <= pop ? 5'd0 : step_reg + 5'd1;
            if (adv) out_valid_reg <= 1'b1;
            else if (res_ready) out_valid_reg <= 1'b0;
        end
    end

    `ACE_ASSERT_IMP(a_step_in_range, clk, rst_n, (cnt_reg != '0), (step_reg < nsteps))
    `ACE_ASSERT_IMP(a_no_overflow, clk, rst_n, push, (cnt_reg < (AW+1)'(QueueDepth)))
    `ACE_ASSERT_NEXT(a_pop_restarts, clk, rst_n, pop, (step_reg == 5'd0))
endmodule
`default_nettype wire

// ----- rtl/ata_pio_lba48_command_engine.sv -----
// ATA PIO LBA48 host command sequencer. Each input beat (start request, status
// reply or data word) is taken by the sequencer, which classifies it and,
// when the beat causes results, queues a job; the result generator expands each job into
// 1 to 16 result beats, one per cycle while the result side is ready, the final one marked
// last. The first result of a beat passes through the job queue and the output register.
// A new beat is accepted every cycle while the four-entry job queue has room, so the
// sustained rate is one input per cycle when each input yields at most one result and is
// otherwise set by the result count and by back-pressure on the result side. Registers:
// enabled at 0x0, retry_limit at 0x4, poll_limit at 0x8.
`default_nettype none
module ata_pio_lba48_command_engine #(
    parameter int WORDS_PER_SECTOR = ace_pkg::WordsPerSectorDef,
    parameter int MAX_SECTORS      = ace_pkg::MaxSectorsDef
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ace_stream_if.sink       in_ch,
    ace_stream_if.source     out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ace_pkg::*;

    logic        enabled_reg;
    logic [2:0]  retry_reg;
    logic [19:0] poll_reg;
    logic        job_valid, job_ready;
    job_t        job;
    req_t        req;
    res_t        res;

    assign pready = 1'b1;
    assign req = in_ch.payload;
    assign out_ch.payload = res;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            retry_reg <= 3'd3;
            poll_reg <= 20'd1000000;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                CFG_ENABLED: enabled_reg <= pwdata[0];
                CFG_RETRY:   retry_reg <= pwdata[2:0];
                CFG_POLL:    poll_reg <= pwdata[19:0];
                default:     ;
            endcase
        end
    end

    // register read
    always_comb
    begin
        case (paddr[3:2])
            CFG_ENABLED: prdata = {31'd0, enabled_reg};
            CFG_RETRY:   prdata = {29'd0, retry_reg};
            CFG_POLL:    prdata = {12'd0, poll_reg};
            default:     prdata = '0;
        endcase
    end

    ace_front #(
        .WORDS_PER_SECTOR(WORDS_PER_SECTOR),
        .MAX_SECTORS(MAX_SECTORS)
    ) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .req(req),
        .enabled(enabled_reg), .retry_limit(retry_reg), .poll_limit(poll_reg),
        .job_valid(job_valid), .job(job), .job_ready(job_ready)
    );

    ace_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(job_valid), .job(job), .job_ready(job_ready),
        .res_valid(out_ch.valid), .res(res), .res_ready(out_ch.ready)
    );
endmodule
`default_nettype wire

// ----- tb/ata_pio_lba48_command_engine_tb.sv -----
`default_nettype none
module ata_pio_lba48_command_engine_tb;
    import ace_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RAND_PER_PASS = 35;

    typedef enum int {
        SEQ_IDLE, SEQ_SEL_BSY, SEQ_SEC_BSY, SEQ_SEC_DRQ, SEQ_RD_DATA, SEQ_WR_DATA, SEQ_FLUSH_BSY
    } seq_phase_e;

    // behavioural copy of the sequencer plus the queue of bus beats it expects
    class ata_sequence_scoreboard;
        bit          enabled;
        bit [2:0]    retry_limit;
        bit [19:0]   poll_limit;
        seq_phase_e  phase;
        bit          is_write;
        bit [47:0]   saved_lba;
        bit [8:0]    saved_count;
        int unsigned sectors_left;
        int unsigned words_left;
        int unsigned poll_count;
        bit [2:0]    attempts;
        res_t        step_beats[$];
        res_t        pending_beats[$];
        int          errors;

        function new();
            enabled = 0;
            retry_limit = 3;
            poll_limit = 20'd1000000;
            phase = SEQ_IDLE;
            errors = 0;
        endfunction

        function void emit(logic [2:0] op, logic [3:0] rs, logic [15:0] val,
                           logic hv, logic [15:0] hw, logic done, logic [1:0] outc);
            res_t r;
            r = '0;
            r.bus_op = op;
            r.reg_sel = rs;
            r.bus_value = val;
            r.host_word_valid = hv;
            r.host_word = hw;
            r.done_res = done;
            r.outcome = outc;
            if (step_beats.size() < JobMax)
                step_beats.push_back(r);
        endfunction

        function void settle4();
            repeat (4) emit(OP_SETTLE, 4'd8, 16'h0, 1'b0, 16'h0, 1'b0, OUT_OK);
        endfunction

        function void start_poll(seq_phase_e nxt);
            poll_count = 1;
            phase = nxt;
            emit(OP_STAT, 4'd7, 16'h0, 1'b0, 16'h0, 1'b0, OUT_OK);
        endfunction

        function void finish(logic [1:0] outc);
            phase = SEQ_IDLE;
            emit(OP_NONE, 4'd0, 16'h0, 1'b0, 16'h0, 1'b1, outc);
        endfunction

        function void begin_attempt();
            sectors_left = saved_count;
            words_left = 0;
            emit(OP_BWR, 4'd6, 16'h40, 1'b0, 16'h0, 1'b0, OUT_OK);
            settle4();
            start_poll(SEQ_SEL_BSY);
        endfunction

        // soft reset, then retry or give up
        function void fail_attempt();
            bit [2:0] lim;
            lim = (retry_limit != 0) ? retry_limit : 3'd1;
            emit(OP_BWR, 4'd8, 16'h04, 1'b0, 16'h0, 1'b0, OUT_OK);
            settle4();
            emit(OP_BWR, 4'd8, 16'h00, 1'b0, 16'h0, 1'b0, OUT_OK);
            settle4();
            attempts = attempts + 3'd1;
            if (attempts >= lim || !enabled)
                finish(OUT_FAIL);
            else
                begin_attempt();
        endfunction

        function void repoll();
            int unsigned lim;
            lim = (poll_limit != 0) ? poll_limit : 1;
            if (poll_count >= lim)
            begin
                fail_attempt();
                return;
            end
            poll_count++;
            emit(OP_STAT, 4'd7, 16'h0, 1'b0, 16'h0, 1'b0, OUT_OK);
        endfunction

        // task file high bytes first, then low bytes, then the command
        function void program_task_file();
            emit(OP_BWR, 4'd2, {8'h0, 7'h0, saved_count[8]}, 1'b0, 16'h0, 1'b0, OUT_OK);
            emit(OP_BWR, 4'd3, {8'h0, saved_lba[31:24]}, 1'b0, 16'h0, 1'b0, OUT_OK);
            emit(OP_BWR, 4'd4, {8'h0, saved_lba[39:32]}, 1'b0, 16'h0, 1'b0, OUT_OK);
            emit(OP_BWR, 4'd5, {8'h0, saved_lba[47:40]}, 1'b0, 16'h0, 1'b0, OUT_OK);
            emit(OP_BWR, 4'd2, {8'h0, saved_count[7:0]}, 1'b0, 16'h0, 1'b0, OUT_OK);
            emit(OP_BWR, 4'd3, {8'h0, saved_lba[7:0]}, 1'b0, 16'h0, 1'b0, OUT_OK);
            emit(OP_BWR, 4'd4, {8'h0, saved_lba[15:8]}, 1'b0, 16'h0, 1'b0, OUT_OK);
            emit(OP_BWR, 4'd5, {8'h0, saved_lba[23:16]}, 1'b0, 16'h0, 1'b0, OUT_OK);
            emit(OP_BWR, 4'd7, is_write ? 16'h34 : 16'h24, 1'b0, 16'h0, 1'b0, OUT_OK);
            settle4();
            start_poll(SEQ_SEC_BSY);
        endfunction

        function void sector_done();
            if (sectors_left > 0)
                sectors_left--;
            if (sectors_left > 0)
                start_poll(SEQ_SEC_BSY);
            else if (is_write)
            begin
                emit(OP_BWR, 4'd7, 16'hEA, 1'b0, 16'h0, 1'b0, OUT_OK);
                start_poll(SEQ_FLUSH_BSY);
            end
            else
                finish(OUT_OK);
        endfunction

        function void on_status(logic [7:0] s);
            case (phase)
                SEQ_SEL_BSY, SEQ_SEC_BSY, SEQ_FLUSH_BSY:
                begin
                    if (s[7])
                        repoll();
                    else if (s[0])
                        fail_attempt();
                    else if (phase == SEQ_SEL_BSY)
                        program_task_file();
                    else if (phase == SEQ_SEC_BSY)
                        start_poll(SEQ_SEC_DRQ);
                    else
                        finish(OUT_OK);
                end
                SEQ_SEC_DRQ:
                begin
                    if (s[0])
                        fail_attempt();
                    else if (!s[3])
                        repoll();
                    else
                    begin
                        words_left = WordsPerSectorDef;
                        if (is_write)
                            phase = SEQ_WR_DATA;
                        else
                        begin
                            phase = SEQ_RD_DATA;
                            emit(OP_DRD, 4'd0, 16'h0, 1'b0, 16'h0, 1'b0, OUT_OK);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void on_word(logic [15:0] w);
            if (phase == SEQ_RD_DATA)
            begin
                emit(OP_NONE, 4'd0, 16'h0, 1'b1, w, 1'b0, OUT_OK);
                if (words_left > 0)
                    words_left--;
                if (words_left > 0)
                    emit(OP_DRD, 4'd0, 16'h0, 1'b0, 16'h0, 1'b0, OUT_OK);
                else
                    sector_done();
            end
            else if (phase == SEQ_WR_DATA)
            begin
                emit(OP_DWR, 4'd0, w, 1'b0, 16'h0, 1'b0, OUT_OK);
                if (words_left > 0)
                    words_left--;
                if (words_left == 0)
                    sector_done();
            end
        endfunction

        function void on_start(bit wr, logic [47:0] a, logic [8:0] c);
            logic [63:0] end_lba;
            end_lba = {16'h0, a} + {55'h0, c} - 64'd1;
            if (phase != SEQ_IDLE)
            begin
                emit(OP_NONE, 4'd0, 16'h0, 1'b0, 16'h0, 1'b1, OUT_REJ);
                return;
            end
            if (!enabled || c == 0 || c > MaxSectorsDef || end_lba > {16'h0, LbaMax})
            begin
                finish(OUT_REJ);
                return;
            end
            is_write = wr;
            saved_lba = a;
            saved_count = c;
            attempts = 0;
            begin_attempt();
        endfunction

        // accepted input beat: work out the beats it causes
        function void note_input(req_t r);
            step_beats.delete();
            case (r.req_type)
                REQ_READ, REQ_WRITE: on_start(r.req_type == REQ_WRITE, r.lba, r.num_sectors);
                REQ_STATUS: on_status(r.status);
                default: on_word(r.data_word);
            endcase
            if (step_beats.size() > 0)
                step_beats[step_beats.size() - 1].last = 1'b1;
            foreach (step_beats[i])
                pending_beats.push_back(step_beats[i]);
        endfunction

        function void field_check(string name, logic [15:0] exp_v, logic [15:0] act_v);
            if (exp_v !== act_v)
            begin
                $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(res_t r);
            res_t e;
            if (pending_beats.size() == 0)
            begin
                $display("%0t unexpected beat expected none actual %h", $time, r);
                errors++;
                return;
            end
            e = pending_beats.pop_front();
            field_check("bus_op", e.bus_op, r.bus_op);
            field_check("reg_sel", e.reg_sel, r.reg_sel);
            field_check("bus_value", e.bus_value, r.bus_value);
            field_check("host_word_valid", e.host_word_valid, r.host_word_valid);
            field_check("host_word", e.host_word, r.host_word);
            field_check("done_res", e.done_res, r.done_res);
            field_check("outcome", e.outcome, r.outcome);
            field_check("last", e.last, r.last);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ace_stream_if #(.W($bits(req_t))) in_ch ();
    ace_stream_if #(.W($bits(res_t))) out_ch ();

    ata_pio_lba48_command_engine uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ata_sequence_scoreboard seq_sb = new();
    bit calm = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    // full sector transfers still allowed; the rest are cut short at the drq wait
    int xfer_left = 1;

    // clock
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // result side back-pressure in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 7);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // result beat monitor
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            seq_sb.check_result(res_t'(out_ch.payload));
    end

    // watchdog on cycles with nothing moving
    always @(posedge clk)
    begin
        if (!rst_n || psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            CFG_ENABLED: seq_sb.enabled = val[0];
            CFG_RETRY:   seq_sb.retry_limit = val[2:0];
            default:     seq_sb.poll_limit = val[19:0];
        endcase
    endtask

    // one input beat, held until taken
    task automatic send_beat(req_t r);
        in_ch.valid <= 1'b1;
        in_ch.payload <= r;
        do
            @(posedge clk);
        while (!in_ch.ready);
        seq_sb.note_input(r);
    endtask

    task automatic send_gap();
        int n;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, 8);
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic req_t mk_req(logic [1:0] t, logic [47:0] a, logic [8:0] c,
                                    logic [7:0] s, logic [15:0] w);
        req_t r;
        r.req_type = t;
        r.lba = a;
        r.num_sectors = c;
        r.status = s;
        r.data_word = w;
        return r;
    endfunction

    // next beat from the device or host, shaped by where the sequencer stands
    function automatic req_t next_beat(bit drain);
        req_t r;
        int p;
        bit abort_run;
        r = mk_req(2'($urandom_range(0, 3)), 48'({$urandom, $urandom}), 9'($urandom),
                   8'($urandom), 16'($urandom));
        p = $urandom_range(0, 99);
        abort_run = seq_sb.saved_count != 9'd1 || xfer_left == 0;
        if (!drain && p < 4)
            return r;
        case (seq_sb.phase)
            SEQ_IDLE:
            begin
                r.req_type = $urandom_range(0, 1) ? REQ_WRITE : REQ_READ;
                p = $urandom_range(0, 99);
                if (p < 80)
                    r.num_sectors = 9'($urandom_range(1, 2));
                else if (p < 88)
                    r.num_sectors = 9'($urandom_range(3, 256));
                else if (p < 93)
                    r.num_sectors = 9'd256;
                if ($urandom_range(0, 9) == 0)
                    r.lba = LbaMax - 48'($urandom_range(0, 3));
            end
            SEQ_SEL_BSY, SEQ_SEC_BSY, SEQ_FLUSH_BSY:
            begin
                r.req_type = REQ_STATUS;
                if (drain)
                    r.status = 8'h01;
                else if (p < 70)
                    r.status = r.status & 8'h7E;
                else if (p < 88)
                    r.status = r.status | 8'h80;
                else
                    r.status = (r.status & 8'h7F) | 8'h01;
            end
            SEQ_SEC_DRQ:
            begin
                r.req_type = REQ_STATUS;
                if (drain || (p < 75 && abort_run))
                    r.status = 8'h01;
                else if (p < 75)
                begin
                    r.status = (r.status & 8'hFE) | 8'h08;
                    xfer_left--;
                end
                else if (p < 90)
                    r.status = r.status & 8'hF6;
                else
                    r.status = r.status | 8'h01;
            end
            default:
            begin
                if (drain || p > 1)
                    r.req_type = REQ_DATA;
            end
        endcase
        return r;
    endfunction

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (seq_sb.pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_pass(int count);
        for (int i = 0; i < count; i++)
        begin
            send_gap();
            send_beat(next_beat(0));
        end
        while (seq_sb.phase != SEQ_IDLE)
        begin
            send_gap();
            send_beat(next_beat(1));
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // drive disabled: starts are turned away
        reg_write(CFG_ENABLED, 32'd0);
        send_beat(mk_req(REQ_READ, 48'h0, 9'd1, 8'h0, 16'h0));
        wait_idle();

        // directed checks
        reg_write(CFG_ENABLED, 32'd1);
        reg_write(CFG_RETRY, 32'd1);
        reg_write(CFG_POLL, 32'hFFFFF);
        send_beat(mk_req(REQ_STATUS, 48'h0, 9'd0, 8'hFF, 16'h0));
        send_beat(mk_req(REQ_DATA, 48'h0, 9'd0, 8'h0, 16'hFFFF));
        send_beat(mk_req(REQ_READ, 48'h0, 9'd0, 8'h0, 16'h0));
        send_beat(mk_req(REQ_READ, 48'h0, 9'd257, 8'h0, 16'h0));
        send_beat(mk_req(REQ_WRITE, 48'h0, 9'd511, 8'h0, 16'h0));
        send_beat(mk_req(REQ_WRITE, LbaMax, 9'd2, 8'h0, 16'h0));
        send_beat(mk_req(REQ_READ, LbaMax, 9'd1, 8'h0, 16'h0));
        send_beat(mk_req(REQ_READ, 48'h5, 9'd1, 8'h0, 16'h0));
        send_beat(mk_req(REQ_DATA, 48'h0, 9'd0, 8'h0, 16'h1234));
        send_beat(mk_req(REQ_STATUS, 48'h0, 9'd0, 8'h80, 16'h0));
        send_beat(mk_req(REQ_STATUS, 48'h0, 9'd0, 8'h00, 16'h0));
        send_beat(mk_req(REQ_STATUS, 48'h0, 9'd0, 8'h01, 16'h0));
        send_beat(mk_req(REQ_WRITE, 48'h0, 9'd256, 8'h0, 16'h0));
        send_beat(mk_req(REQ_STATUS, 48'h0, 9'd0, 8'h00, 16'h0));
        send_beat(mk_req(REQ_STATUS, 48'h0, 9'd0, 8'h00, 16'h0));
        send_beat(mk_req(REQ_STATUS, 48'h0, 9'd0, 8'h81, 16'h0));
        send_beat(mk_req(REQ_STATUS, 48'h0, 9'd0, 8'h09, 16'h0));
        send_beat(mk_req(REQ_WRITE, 48'h0123_4567_89AB, 9'd1, 8'h0, 16'h0));
        random_pass(RAND_PER_PASS);

        // poll timeouts and many retries
        reg_write(CFG_RETRY, 32'd7);
        reg_write(CFG_POLL, 32'd1);
        random_pass(RAND_PER_PASS);

        reg_write(CFG_RETRY, 32'd3);
        reg_write(CFG_POLL, 32'd3);
        random_pass(RAND_PER_PASS);

        // last stretch without idling
        calm = 1;
        reg_write(CFG_RETRY, 32'd2);
        reg_write(CFG_POLL, 32'd1000000);
        random_pass(RAND_PER_PASS);

        if (seq_sb.errors == 0 && seq_sb.pending_beats.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
